>>> src/assert_macros.svh
// Assertion macros shared by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising clock, off while reset is low.
`define ASSERT_AT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    `ASSERT_AT(lbl, clk, rstn, !(cond))

`endif

>>> src/bfd_pkg.sv
// Types and constants shared by the bit-field decoder modules.
`default_nettype none

package bfd_pkg;

    localparam int WORD_BITS        = 32;
    localparam int STORE_WORDS      = 256;
    localparam int VARINT_MAX_BYTES = 5;

    localparam int ADDR_W    = $clog2(STORE_WORDS);
    localparam int OFF_W     = $clog2(WORD_BITS);
    localparam int STORE_END = STORE_WORDS * WORD_BITS;
    localparam int CUR_W     = $clog2(STORE_END + 1);

    // item field widths
    localparam int OP_W   = 3;
    localparam int IDX_W  = 8;
    localparam int DATA_W = 32;
    localparam int CNT_W  = 6;
    localparam int NPOS_W = 13;
    localparam int VAL_W  = 32;
    localparam int POS_W  = 14;

    // bits taken by one decode step: 0 to VAL_W
    localparam int NB_W  = $clog2(VAL_W + 1);
    localparam int GRP_W = 3;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE  = 3'd0,
        OP_SET    = 3'd1,
        OP_RAW    = 3'd2,
        OP_PREFIX = 3'd3,
        OP_UNARY  = 3'd4,
        OP_VARINT = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ACC_KEEP,
        ACC_LOAD,
        ACC_EXT,
        ACC_GROUP
    } acc_mode_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EMIT,
        S_RAW,
        S_PFX_HEAD,
        S_PFX_EXT,
        S_UNA_PFX,
        S_UNA_VAL,
        S_VAR
    } state_t;

    typedef struct packed {
        logic             start;
        logic             wr_word;
        logic             set_cursor;
        logic             step;
        logic             last;
        logic             emit;
        acc_mode_t        mode;
        logic [NB_W-1:0]  nbits;
        logic [GRP_W-1:0] grp;
    } cmd_t;

    typedef struct packed {
        logic       out_full;
        logic [7:0] field_lo;
    } sts_t;

endpackage

`default_nettype wire

>>> src/bfd_if.sv
// Request and result channel interfaces of the bit-field decoder.
`default_nettype none

interface bfd_req_if;
    logic                         valid;
    logic                         ready;
    logic [bfd_pkg::OP_W-1:0]     op;
    logic [bfd_pkg::IDX_W-1:0]    word_index;
    logic [bfd_pkg::DATA_W-1:0]   word_data;
    logic [bfd_pkg::CNT_W-1:0]    bit_count;
    logic [bfd_pkg::NPOS_W-1:0]   new_position;

    modport source (output valid, op, word_index, word_data, bit_count, new_position,
                    input ready);
    modport sink   (input valid, op, word_index, word_data, bit_count, new_position,
                    output ready);
endinterface

interface bfd_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [bfd_pkg::VAL_W-1:0]   value;
    logic [bfd_pkg::POS_W-1:0]   position;
    logic                        overrun;

    modport source (output valid, value, position, overrun, input ready);
    modport sink   (input valid, value, position, overrun, output ready);
endinterface

`default_nettype wire

>>> src/bitstream_field_decoder_core.sv
// Bit-field decoder top level: word store with a bit cursor and field decodes.
//
// req carries one item per handshake (valid and ready high at a rising edge):
// op 0 writes word_data into slot word_index, op 1 loads the cursor from
// new_position, op 2 reads bit_count raw bits, op 3 a 6-bit-prefixed integer,
// op 4 a unary-prefixed integer, op 5 a 7-bit-group varint. rsp returns one
// item for each request: value, the cursor after the item, and overrun.
// A decode runs as 1 to 5 bit-read steps. Each step needs the two store words
// under the cursor, read from the two-port store into registers, so after each
// step the cursor register updates and the read registers reload before the
// next step. The result is registered with the final step, and a new item is
// taken only once the previous one has reached its final step or emit.
// Reset clears the cursor and the result valid flag; store contents stay
// undefined until written. A stalled rsp holds its item; the next request is
// still taken, and its final step waits until the result register drains.
`default_nettype none

module bitstream_field_decoder_core (
    input  wire logic clk,
    input  wire logic rst_n,
    bfd_req_if.sink   req,
    bfd_rsp_if.source rsp
);
    import bfd_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic req_ready;

    assign req.ready = req_ready;

    bfd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .op        (req.op),
        .bit_count (req.bit_count),
        .req_ready (req_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    bfd_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .word_index   (req.word_index),
        .word_data    (req.word_data),
        .new_position (req.new_position),
        .rsp          (rsp)
    );

endmodule

`default_nettype wire

>>> src/bfd_datapath.sv
// Word store, bit cursor, field extractor, accumulator and result register.
`default_nettype none
`include "assert_macros.svh"

module bfd_datapath (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire bfd_pkg::cmd_t              cmd,
    output bfd_pkg::sts_t                   sts,
    input  wire logic [bfd_pkg::IDX_W-1:0]  word_index,
    input  wire logic [bfd_pkg::DATA_W-1:0] word_data,
    input  wire logic [bfd_pkg::NPOS_W-1:0] new_position,
    bfd_rsp_if.source                       rsp
);
    import bfd_pkg::*;

    logic [WORD_BITS-1:0] mem [STORE_WORDS];
    logic [WORD_BITS-1:0] rd_lo_reg, rd_hi_reg;

    logic [CUR_W-1:0] cursor_reg, cursor_next;
    logic [VAL_W-1:0] acc_reg, acc_next;
    logic             ovf_reg, ovf_next;

    logic             out_valid_reg, out_valid_next;
    logic [VAL_W-1:0] value_reg, value_next;
    logic [POS_W-1:0] position_reg, position_next;
    logic             overrun_reg, overrun_next;

    logic [ADDR_W-1:0]      cur_word, nxt_word;
    logic [2*WORD_BITS-1:0] window;
    logic [VAL_W:0]         len_bit;
    logic [VAL_W-1:0]       mask, field, grp_val;
    logic [4:0]             grp_shift;
    logic [CUR_W:0]         sum, np_ext;
    logic                   step_ovf;
    logic [CUR_W-1:0]       cursor_step, cursor_set;

    assign cur_word = cursor_reg[OFF_W +: ADDR_W];
    assign nxt_word = cur_word + 1'b1;   // wraps to the store start

    always_ff @(posedge clk) begin
        if (cmd.wr_word) begin
            mem[word_index[ADDR_W-1:0]] <= WORD_BITS'(word_data);
        end
        rd_lo_reg <= mem[cur_word];
        rd_hi_reg <= mem[nxt_word];
    end

    // LSB-first field at the cursor, masked to the step length
    assign window  = {rd_hi_reg, rd_lo_reg} >> cursor_reg[OFF_W-1:0];
    assign len_bit = (VAL_W + 1)'(1) << cmd.nbits;
    assign mask    = len_bit[VAL_W-1:0] - 1'b1;
    assign field   = window[VAL_W-1:0] & mask;

    assign grp_shift = 5'(cmd.grp) * 5'd7;
    assign grp_val   = VAL_W'(field[6:0]) << grp_shift;

    assign sum         = {1'b0, cursor_reg} + (CUR_W + 1)'(cmd.nbits);
    assign step_ovf    = sum > (CUR_W + 1)'(STORE_END);
    assign cursor_step = step_ovf ? CUR_W'(STORE_END) : sum[CUR_W-1:0];
    assign np_ext      = (CUR_W + 1)'(new_position);
    assign cursor_set  = (np_ext > (CUR_W + 1)'(STORE_END)) ? CUR_W'(STORE_END)
                                                            : np_ext[CUR_W-1:0];

    always_comb begin
        acc_next    = acc_reg;
        ovf_next    = ovf_reg;
        cursor_next = cursor_reg;
        if (cmd.start) begin
            acc_next = '0;
            ovf_next = 1'b0;
            if (cmd.set_cursor) begin
                cursor_next = cursor_set;
            end
        end else if (cmd.step) begin
            ovf_next    = ovf_reg | step_ovf;
            cursor_next = cursor_step;
            unique case (cmd.mode)
                ACC_KEEP:  acc_next = acc_reg;
                ACC_LOAD:  acc_next = field;
                ACC_EXT:   acc_next = {field[VAL_W-5:0], acc_reg[3:0]};
                ACC_GROUP: acc_next = acc_reg | grp_val;
            endcase
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        value_next     = value_reg;
        position_next  = position_reg;
        overrun_next   = overrun_reg;
        if (cmd.emit || (cmd.step && cmd.last)) begin
            out_valid_next = 1'b1;
            value_next     = acc_next;
            position_next  = POS_W'(cursor_next);
            overrun_next   = ovf_next;
        end else if (rsp.ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cursor_reg    <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            cursor_reg    <= cursor_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        acc_reg      <= acc_next;
        value_reg    <= value_next;
        position_reg <= position_next;
        overrun_reg  <= overrun_next;
    end

    assign sts.out_full = out_valid_reg & ~rsp.ready;
    assign sts.field_lo = field[7:0];

    assign rsp.valid    = out_valid_reg;
    assign rsp.value    = value_reg;
    assign rsp.position = position_reg;
    assign rsp.overrun  = overrun_reg;

    `ASSERT_AT(a_cursor_range, clk, rst_n, cursor_reg <= CUR_W'(STORE_END))
    `ASSERT_AT(a_overrun_sat, clk, rst_n,
        (out_valid_reg && overrun_reg) |-> (position_reg == POS_W'(STORE_END)))
    `ASSERT_AT(a_start_clears, clk, rst_n, cmd.start |=> (acc_reg == '0 && !ovf_reg))

endmodule

`default_nettype wire

>>> src/bfd_ctrl.sv
// Sequencer that splits each decode into bit-read steps.
`default_nettype none
`include "assert_macros.svh"

module bfd_ctrl (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      req_valid,
    input  wire logic [bfd_pkg::OP_W-1:0]  op,
    input  wire logic [bfd_pkg::CNT_W-1:0] bit_count,
    output logic                           req_ready,
    output bfd_pkg::cmd_t                  cmd,
    input  wire bfd_pkg::sts_t             sts
);
    import bfd_pkg::*;

    localparam int PFX_HEAD_BITS = 6;
    localparam int VAR_BYTE_BITS = 8;
    localparam logic [2:0] UNA_LAST = 3'd4;
    localparam logic [GRP_W-1:0] GRP_LAST = GRP_W'(VARINT_MAX_BYTES - 1);

    state_t           state_reg, state_next;
    logic [NB_W-1:0]  cnt_reg, cnt_next;
    logic [1:0]       sel_reg, sel_next;
    logic [2:0]       una_reg, una_next;
    logic [GRP_W-1:0] grp_reg, grp_next;
    logic             data_ok_reg, data_ok_next;
    logic             head_last, var_last;

    function automatic logic [NB_W-1:0] una_bits(input logic [2:0] idx);
        logic [NB_W-1:0] n;
        unique case (idx)
            3'd0:    n = NB_W'(2);
            3'd1:    n = NB_W'(4);
            3'd2:    n = NB_W'(10);
            3'd3:    n = NB_W'(17);
            default: n = NB_W'(31);
        endcase
        return n;
    endfunction

    function automatic logic [NB_W-1:0] ext_bits(input logic [1:0] sel);
        logic [NB_W-1:0] n;
        unique case (sel)
            2'd1:    n = NB_W'(4);
            2'd2:    n = NB_W'(8);
            default: n = NB_W'(28);
        endcase
        return n;
    endfunction

    assign head_last = sts.field_lo[5:4] == 2'd0;
    assign var_last  = !sts.field_lo[7] || (grp_reg == GRP_LAST);

    // outputs
    always_comb begin
        cmd       = '0;
        req_ready = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                req_ready      = 1'b1;
                cmd.start      = req_valid;
                cmd.wr_word    = req_valid && (op == OP_WRITE);
                cmd.set_cursor = req_valid && (op == OP_SET);
            end
            S_EMIT: begin
                cmd.emit = !sts.out_full;
            end
            S_RAW: begin
                cmd.nbits = cnt_reg;
                cmd.mode  = ACC_LOAD;
                cmd.last  = 1'b1;
                cmd.step  = data_ok_reg && !sts.out_full;
            end
            S_PFX_HEAD: begin
                cmd.nbits = NB_W'(PFX_HEAD_BITS);
                cmd.mode  = ACC_LOAD;
                cmd.last  = head_last;
                cmd.step  = data_ok_reg && (!head_last || !sts.out_full);
            end
            S_PFX_EXT: begin
                cmd.nbits = ext_bits(sel_reg);
                cmd.mode  = ACC_EXT;
                cmd.last  = 1'b1;
                cmd.step  = data_ok_reg && !sts.out_full;
            end
            S_UNA_PFX: begin
                cmd.nbits = NB_W'(1);
                cmd.mode  = ACC_KEEP;
                cmd.step  = data_ok_reg;
            end
            S_UNA_VAL: begin
                cmd.nbits = una_bits(una_reg);
                cmd.mode  = ACC_LOAD;
                cmd.last  = 1'b1;
                cmd.step  = data_ok_reg && !sts.out_full;
            end
            S_VAR: begin
                cmd.nbits = NB_W'(VAR_BYTE_BITS);
                cmd.mode  = ACC_GROUP;
                cmd.grp   = grp_reg;
                cmd.last  = var_last;
                cmd.step  = data_ok_reg && (!var_last || !sts.out_full);
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    // next state
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        sel_next     = sel_reg;
        una_next     = una_reg;
        grp_next     = grp_reg;
        data_ok_next = !cmd.step;   // window is re-read after every cursor move
        unique case (state_reg)
            S_IDLE: begin
                if (req_valid) begin
                    una_next = '0;
                    grp_next = '0;
                    cnt_next = (bit_count > CNT_W'(VAL_W)) ? NB_W'(VAL_W) : NB_W'(bit_count);
                    unique case (op_t'(op))
                        OP_RAW:    state_next = S_RAW;
                        OP_PREFIX: state_next = S_PFX_HEAD;
                        OP_UNARY:  state_next = S_UNA_PFX;
                        OP_VARINT: state_next = S_VAR;
                        default:   state_next = S_EMIT;
                    endcase
                end
            end
            S_EMIT: begin
                if (cmd.emit) begin
                    state_next = S_IDLE;
                end
            end
            S_PFX_HEAD: begin
                if (cmd.step) begin
                    sel_next   = sts.field_lo[5:4];
                    state_next = head_last ? S_IDLE : S_PFX_EXT;
                end
            end
            S_UNA_PFX: begin
                if (cmd.step) begin
                    if (!sts.field_lo[0]) begin
                        una_next = una_reg + 1'b1;
                    end
                    if (sts.field_lo[0] || (una_reg == UNA_LAST - 1'b1)) begin
                        state_next = S_UNA_VAL;
                    end
                end
            end
            S_VAR: begin
                if (cmd.step) begin
                    if (var_last) begin
                        state_next = S_IDLE;
                    end else begin
                        grp_next = grp_reg + 1'b1;
                    end
                end
            end
            S_RAW, S_PFX_EXT, S_UNA_VAL: begin
                if (cmd.step) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            sel_reg     <= '0;
            una_reg     <= '0;
            grp_reg     <= '0;
            data_ok_reg <= 1'b1;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            sel_reg     <= sel_next;
            una_reg     <= una_next;
            grp_reg     <= grp_next;
            data_ok_reg <= data_ok_next;
        end
    end

    `ASSERT_NEVER(a_no_load_when_full, clk, rst_n,
        (cmd.emit || (cmd.step && cmd.last)) && sts.out_full)
    `ASSERT_AT(a_refetch_gap, clk, rst_n, !data_ok_reg |-> $past(cmd.step))
    `ASSERT_AT(a_counts, clk, rst_n, (una_reg <= UNA_LAST) && (grp_reg <= GRP_LAST))

endmodule

`default_nettype wire
